>>> sv/contiguous_block_allocator_unit_assert.svh
// assertion macros used by the checker file
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define CBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/cba_pkg.sv
// ----------------------------------------------------------------------------
// cba_pkg
// shared widths, default sizes and codes of the contiguous block allocator
// ----------------------------------------------------------------------------
package cba_pkg;

  localparam int DISK_BLOCKS_DEF = 1024;
  localparam int NUM_ENTRIES_DEF = 64;
  localparam int BLOCK_BYTES_DEF = 1024;

  localparam int CMD_W    = 2;
  localparam int KEY_W    = 64;
  localparam int SIZE_W   = 21;
  localparam int IDX_W    = 6;
  localparam int STATUS_W = 3;
  localparam int START_W  = 10;
  localparam int BLOCKS_W = 11;
  localparam int COUNT_W  = 7;

  localparam int FM_WORD_W = 8;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam cmd_t CMD_CREATE = 2'd0;
  localparam cmd_t CMD_DELETE = 2'd1;
  localparam cmd_t CMD_READ   = 2'd2;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_FULL     = 3'd1;
  localparam status_t ST_NOSPACE  = 3'd2;
  localparam status_t ST_NOTFOUND = 3'd3;
  localparam status_t ST_ZERO     = 3'd4;
  localparam status_t ST_BADINDEX = 3'd5;

endpackage

>>> sv/cba_ram.sv
// ----------------------------------------------------------------------------
// cba_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module cba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/contiguous_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// contiguous_block_allocator_unit
// first-fit contiguous block allocator with a free map and an ordered file table
// ----------------------------------------------------------------------------
// in channel: one command per transfer (create, delete by key, read by index).
// out channel: one result per command with status, the entry touched, the
// file count and the blocks in use after the command.
// the free map sits in a ram of 8-bit words, the table in a second ram.
// steps per command, from its transfer to the load of the result register:
//   read: the entry is read from the table
//   failed create before the scan, bad index or unknown command: straight to the result
//   create too large for the disk: rejected once the size is in blocks
//   create: free-map words are scanned up to the first fit, then each word
//   of the run is read and marked; no free run long enough: all are scanned
//   delete: the table is searched up to the key, each word is freed, then
//   the later entries move up; a missing key: the whole table is searched
// one command is in flight at a time; in_stall is high until it finishes.
// after reset the free map is cleared one word per cycle, with in_stall high.
// the result sits in an output register; a new command is taken while it
// waits, and the block holds its next result until out_stall drops.
// ----------------------------------------------------------------------------
module contiguous_block_allocator_unit import cba_pkg::*; #(
  parameter int DISK_BLOCKS = DISK_BLOCKS_DEF,
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [KEY_W-1:0]    in_file_key,
  input  logic [SIZE_W-1:0]   in_file_size,
  input  logic [IDX_W-1:0]    in_entry_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [KEY_W-1:0]    out_key,
  output logic [SIZE_W-1:0]   out_size,
  output logic [START_W-1:0]  out_start,
  output logic [BLOCKS_W-1:0] out_blocks,
  output logic [COUNT_W-1:0]  out_file_count,
  output logic [BLOCKS_W-1:0] out_blocks_in_use
);

  localparam int FM_DEPTH = (DISK_BLOCKS + FM_WORD_W - 1) / FM_WORD_W;
  localparam int FM_AW    = (FM_DEPTH > 1) ? $clog2(FM_DEPTH) : 1;
  localparam int FM_CW    = $clog2(FM_DEPTH + 1);
  localparam int FM_SH    = $clog2(FM_WORD_W);
  localparam int ENT_AW   = $clog2(NUM_ENTRIES);
  localparam int ENT_CW   = $clog2(NUM_ENTRIES + 1);
  localparam int SW       = $clog2(DISK_BLOCKS);
  localparam int CW       = $clog2(DISK_BLOCKS + 1);
  localparam int BW       = $clog2(FM_DEPTH * FM_WORD_W + 1);
  localparam int NEED_W   = SIZE_W + 1;
  localparam int EW       = KEY_W + SIZE_W + SW + CW;
  localparam int RC_K     = NEED_W + $clog2(BLOCK_BYTES);
  localparam int RC_MW    = NEED_W + 1;
  localparam int RC_PW    = NEED_W + RC_MW;
  localparam logic [RC_MW-1:0] RC_MUL = RC_MW'(((longint'(1) << RC_K)
                                        + longint'(BLOCK_BYTES - 1))
                                        / longint'(BLOCK_BYTES));

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_DIV     = 4'd2;
  localparam logic [3:0] S_SCAN    = 4'd3;
  localparam logic [3:0] S_MARK_RD = 4'd4;
  localparam logic [3:0] S_MARK_WR = 4'd5;
  localparam logic [3:0] S_APPEND  = 4'd6;
  localparam logic [3:0] S_FIND    = 4'd7;
  localparam logic [3:0] S_SHIFT   = 4'd8;
  localparam logic [3:0] S_RD_ISS  = 4'd9;
  localparam logic [3:0] S_RD_DAT  = 4'd10;
  localparam logic [3:0] S_FIN     = 4'd11;

  logic [3:0]          state_r, state_nxt;
  logic [FM_AW-1:0]    clr_r, clr_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [ENT_CW-1:0]   total_r, total_nxt;
  logic [CW-1:0]       used_r, used_nxt;
  logic [CW-1:0]       need_r, need_nxt;
  logic [FM_CW-1:0]    sa_r, sa_nxt;
  logic [FM_AW-1:0]    wi_r, wi_nxt;
  logic                dv_r, dv_nxt;
  logic [CW-1:0]       run_r, run_nxt;
  logic [SW-1:0]       rs_r, rs_nxt;
  logic [CW-1:0]       rn_r, rn_nxt;
  logic [FM_AW-1:0]    mp_r, mp_nxt;
  logic [FM_AW-1:0]    ml_r, ml_nxt;
  logic                set_r, set_nxt;
  logic [ENT_CW-1:0]   ep_r, ep_nxt;
  logic [ENT_AW-1:0]   ei_r, ei_nxt;
  logic [ENT_AW-1:0]   pos_r, pos_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [KEY_W-1:0]    res_key_r, res_key_nxt;
  logic [SIZE_W-1:0]   res_size_r, res_size_nxt;
  logic [SW-1:0]       res_start_r, res_start_nxt;
  logic [CW-1:0]       res_cnt_r, res_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r;
  logic [KEY_W-1:0]    out_key_r;
  logic [SIZE_W-1:0]   out_size_r;
  logic [START_W-1:0]  out_start_r;
  logic [BLOCKS_W-1:0] out_blocks_r;
  logic [COUNT_W-1:0]  out_file_count_r;
  logic [BLOCKS_W-1:0] out_blocks_in_use_r;

  logic                fm_we;
  logic [FM_AW-1:0]    fm_waddr, fm_raddr;
  logic [FM_WORD_W-1:0] fm_wdata, fm_rdata, fm_mask;
  logic                tb_we;
  logic [ENT_AW-1:0]   tb_waddr, tb_raddr;
  logic [EW-1:0]       tb_wdata, tb_rdata;

  logic [KEY_W-1:0]    tb_key;
  logic [SIZE_W-1:0]   tb_size;
  logic [SW-1:0]       tb_start;
  logic [CW-1:0]       tb_cnt;

  logic [NEED_W-1:0]   rc_num;
  logic [RC_PW-1:0]    rc_prod;
  logic [NEED_W-1:0]   need_w;
  logic [CW-1:0]       run_v;
  logic                hit;
  logic [SW-1:0]       hit_start;
  logic [BW-1:0]       blk, mblk;
  logic                blk_free;
  logic                fin_go;

  assign {tb_key, tb_size, tb_start, tb_cnt} = tb_rdata;

  cba_ram #(.WIDTH(FM_WORD_W), .DEPTH(FM_DEPTH)) u_fm_ram (
    .clk   (clk),
    .we    (fm_we),
    .waddr (fm_waddr),
    .wdata (fm_wdata),
    .raddr (fm_raddr),
    .rdata (fm_rdata)
  );

  cba_ram #(.WIDTH(EW), .DEPTH(NUM_ENTRIES)) u_tb_ram (
    .clk   (clk),
    .we    (tb_we),
    .waddr (tb_waddr),
    .wdata (tb_wdata),
    .raddr (tb_raddr),
    .rdata (tb_rdata)
  );

  // size in blocks, rounded up, by reciprocal multiplication
  always_comb begin
    rc_num  = NEED_W'(size_r) + NEED_W'(BLOCK_BYTES - 1);
    rc_prod = RC_PW'(rc_num) * RC_PW'(RC_MUL);
  end

  // first-fit search over one free-map word
  always_comb begin
    run_v     = run_r;
    hit       = 1'b0;
    hit_start = '0;
    blk       = '0;
    blk_free  = 1'b0;
    for (int i = 0; i < FM_WORD_W; i++) begin
      blk      = BW'({wi_r, FM_SH'(i)});
      blk_free = !fm_rdata[i] && (blk < BW'(DISK_BLOCKS));
      run_v    = blk_free ? run_v + CW'(1) : '0;
      if (!hit && blk_free && (run_v == need_r)) begin
        hit       = 1'b1;
        hit_start = SW'(blk + BW'(1) - BW'(need_r));
      end
    end
  end

  // mask of the region inside the current word
  always_comb begin
    fm_mask = '0;
    mblk    = '0;
    for (int i = 0; i < FM_WORD_W; i++) begin
      mblk       = BW'({mp_r, FM_SH'(i)});
      fm_mask[i] = (mblk >= BW'(rs_r)) && (mblk < BW'(rs_r) + BW'(rn_r));
    end
  end

  assign fin_go = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    key_nxt        = key_r;
    size_nxt       = size_r;
    total_nxt      = total_r;
    used_nxt       = used_r;
    need_nxt       = need_r;
    sa_nxt         = sa_r;
    wi_nxt         = wi_r;
    dv_nxt         = dv_r;
    run_nxt        = run_r;
    rs_nxt         = rs_r;
    rn_nxt         = rn_r;
    mp_nxt         = mp_r;
    ml_nxt         = ml_r;
    set_nxt        = set_r;
    ep_nxt         = ep_r;
    ei_nxt         = ei_r;
    pos_nxt        = pos_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    res_size_nxt   = res_size_r;
    res_start_nxt  = res_start_r;
    res_cnt_nxt    = res_cnt_r;
    need_w         = '0;

    fm_we    = 1'b0;
    fm_waddr = mp_r;
    fm_wdata = set_r ? (fm_rdata | fm_mask) : (fm_rdata & ~fm_mask);
    fm_raddr = mp_r;
    tb_we    = 1'b0;
    tb_waddr = ENT_AW'(total_r);
    tb_wdata = {key_r, size_r, rs_r, rn_r};
    tb_raddr = ENT_AW'(ep_r);

    case (state_r)
      S_CLR: begin
        fm_we    = 1'b1;
        fm_waddr = clr_r;
        fm_wdata = '0;
        clr_nxt  = clr_r + FM_AW'(1);
        if (clr_r == FM_AW'(FM_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          key_nxt        = in_file_key;
          size_nxt       = in_file_size;
          res_status_nxt = ST_OK;
          res_key_nxt    = '0;
          res_size_nxt   = '0;
          res_start_nxt  = '0;
          res_cnt_nxt    = '0;
          case (in_cmd)
            CMD_CREATE: begin
              if (32'(total_r) >= NUM_ENTRIES) begin
                res_status_nxt = ST_FULL;
                state_nxt      = S_FIN;
              end else if (in_file_size == '0) begin
                res_status_nxt = ST_ZERO;
                state_nxt      = S_FIN;
              end else begin
                state_nxt = S_DIV;
              end
            end
            CMD_DELETE: begin
              ep_nxt    = '0;
              dv_nxt    = 1'b0;
              state_nxt = S_FIND;
            end
            CMD_READ: begin
              if (32'(in_entry_index) >= 32'(total_r)) begin
                res_status_nxt = ST_BADINDEX;
                state_nxt      = S_FIN;
              end else begin
                ep_nxt    = ENT_CW'(in_entry_index);
                state_nxt = S_RD_ISS;
              end
            end
            default: begin
              res_status_nxt = ST_BADINDEX;
              state_nxt      = S_FIN;
            end
          endcase
        end
      end
      S_DIV: begin
        need_w = NEED_W'(rc_prod >> RC_K);
        if (need_w > NEED_W'(DISK_BLOCKS)) begin
          res_status_nxt = ST_NOSPACE;
          state_nxt      = S_FIN;
        end else begin
          need_nxt  = CW'(need_w);
          sa_nxt    = '0;
          dv_nxt    = 1'b0;
          run_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        fm_raddr = FM_AW'(sa_r);
        dv_nxt   = sa_r < FM_CW'(FM_DEPTH);
        wi_nxt   = FM_AW'(sa_r);
        if (sa_r < FM_CW'(FM_DEPTH)) begin
          sa_nxt = sa_r + FM_CW'(1);
        end
        if (dv_r) begin
          run_nxt = run_v;
        end
        if (dv_r && hit) begin
          rs_nxt    = hit_start;
          rn_nxt    = need_r;
          mp_nxt    = FM_AW'(hit_start >> FM_SH);
          ml_nxt    = FM_AW'((BW'(hit_start) + BW'(need_r) - BW'(1)) >> FM_SH);
          set_nxt   = 1'b1;
          state_nxt = S_MARK_RD;
        end else if (!dv_r && (sa_r == FM_CW'(FM_DEPTH))) begin
          res_status_nxt = ST_NOSPACE;
          state_nxt      = S_FIN;
        end
      end
      S_MARK_RD: begin
        fm_raddr  = mp_r;
        state_nxt = S_MARK_WR;
      end
      S_MARK_WR: begin
        fm_we    = 1'b1;
        fm_waddr = mp_r;
        if (mp_r == ml_r) begin
          if (set_r) begin
            state_nxt = S_APPEND;
          end else begin
            ep_nxt    = ENT_CW'(pos_r) + ENT_CW'(1);
            dv_nxt    = 1'b0;
            state_nxt = S_SHIFT;
          end
        end else begin
          mp_nxt    = mp_r + FM_AW'(1);
          state_nxt = S_MARK_RD;
        end
      end
      S_APPEND: begin
        tb_we          = 1'b1;
        tb_waddr       = ENT_AW'(total_r);
        total_nxt      = total_r + ENT_CW'(1);
        used_nxt       = used_r + rn_r;
        res_status_nxt = ST_OK;
        res_key_nxt    = key_r;
        res_size_nxt   = size_r;
        res_start_nxt  = rs_r;
        res_cnt_nxt    = rn_r;
        state_nxt      = S_FIN;
      end
      S_FIND: begin
        tb_raddr = ENT_AW'(ep_r);
        dv_nxt   = ep_r < total_r;
        ei_nxt   = ENT_AW'(ep_r);
        if (ep_r < total_r) begin
          ep_nxt = ep_r + ENT_CW'(1);
        end
        if (dv_r && (tb_key == key_r)) begin
          res_key_nxt   = tb_key;
          res_size_nxt  = tb_size;
          res_start_nxt = tb_start;
          res_cnt_nxt   = tb_cnt;
          pos_nxt       = ei_r;
          rs_nxt        = tb_start;
          rn_nxt        = tb_cnt;
          mp_nxt        = FM_AW'(tb_start >> FM_SH);
          ml_nxt        = FM_AW'((BW'(tb_start) + BW'(tb_cnt) - BW'(1)) >> FM_SH);
          set_nxt       = 1'b0;
          state_nxt     = S_MARK_RD;
        end else if (!dv_r && (ep_r >= total_r)) begin
          res_status_nxt = ST_NOTFOUND;
          state_nxt      = S_FIN;
        end
      end
      S_SHIFT: begin
        tb_raddr = ENT_AW'(ep_r);
        dv_nxt   = ep_r < total_r;
        ei_nxt   = ENT_AW'(ep_r);
        if (ep_r < total_r) begin
          ep_nxt = ep_r + ENT_CW'(1);
        end
        if (dv_r) begin
          tb_we    = 1'b1;
          tb_waddr = ei_r - ENT_AW'(1);
          tb_wdata = tb_rdata;
        end else if (ep_r >= total_r) begin
          total_nxt      = total_r - ENT_CW'(1);
          used_nxt       = (used_r >= rn_r) ? used_r - rn_r : '0;
          res_status_nxt = ST_OK;
          state_nxt      = S_FIN;
        end
      end
      S_RD_ISS: begin
        tb_raddr  = ENT_AW'(ep_r);
        state_nxt = S_RD_DAT;
      end
      S_RD_DAT: begin
        res_key_nxt   = tb_key;
        res_size_nxt  = tb_size;
        res_start_nxt = tb_start;
        res_cnt_nxt   = tb_cnt;
        state_nxt     = S_FIN;
      end
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if ((state_r == S_FIN) && fin_go) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      total_r     <= '0;
      used_r      <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      total_r     <= total_nxt;
      used_r      <= used_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    size_r       <= size_nxt;
    need_r       <= need_nxt;
    sa_r         <= sa_nxt;
    wi_r         <= wi_nxt;
    run_r        <= run_nxt;
    rs_r         <= rs_nxt;
    rn_r         <= rn_nxt;
    mp_r         <= mp_nxt;
    ml_r         <= ml_nxt;
    set_r        <= set_nxt;
    ep_r         <= ep_nxt;
    ei_r         <= ei_nxt;
    pos_r        <= pos_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_size_r   <= res_size_nxt;
    res_start_r  <= res_start_nxt;
    res_cnt_r    <= res_cnt_nxt;
    if ((state_r == S_FIN) && fin_go) begin
      out_status_r        <= res_status_r;
      out_key_r           <= res_key_r;
      out_size_r          <= res_size_r;
      out_start_r         <= START_W'(res_start_r);
      out_blocks_r        <= BLOCKS_W'(res_cnt_r);
      out_file_count_r    <= COUNT_W'(total_r);
      out_blocks_in_use_r <= BLOCKS_W'(used_r);
    end
  end

  assign in_stall          = state_r != S_IDLE;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_key           = out_key_r;
  assign out_size          = out_size_r;
  assign out_start         = out_start_r;
  assign out_blocks        = out_blocks_r;
  assign out_file_count    = out_file_count_r;
  assign out_blocks_in_use = out_blocks_in_use_r;

endmodule

>>> sv/cba_checker.sv
// ----------------------------------------------------------------------------
// cba_checker
// port-level checks of the allocator result channel
// ----------------------------------------------------------------------------
`include "contiguous_block_allocator_unit_assert.svh"

module cba_checker import cba_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STATUS_W-1:0] out_status,
  input logic [KEY_W-1:0]    out_key,
  input logic [SIZE_W-1:0]   out_size,
  input logic [START_W-1:0]  out_start,
  input logic [BLOCKS_W-1:0] out_blocks
);

  `CBA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `CBA_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_status) && $stable(out_key))
  `CBA_ASSERT_NOW(a_fail_zero, out_valid && (out_status != ST_OK), (out_key == '0) && (out_size == '0) && (out_start == '0) && (out_blocks == '0))
  `CBA_ASSERT_NOW(a_ok_blocks, out_valid && (out_status == ST_OK), (out_blocks != '0) && (out_size != '0))

endmodule

bind contiguous_block_allocator_unit cba_checker u_cba_checker (.*);
